FILE: hw/rtl/fca_pkg.sv
// ----------------------------------------------------------------------------
// fca_pkg: shared types and constants for the chain allocator
// Link-table geometry, item formats, mode and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package fca_pkg;

  localparam int unsigned NUM_BLOCKS = 256;
  // 256 is the end-of-chain code and head_block is 8 bits, so at most 256 usable
  localparam int unsigned USABLE     = (NUM_BLOCKS < 256) ? NUM_BLOCKS : 256;
  localparam int unsigned IDX_W      = $clog2(USABLE);
  localparam int unsigned STEP_W     = $clog2(USABLE + 1);
  localparam int unsigned HEAD_W     = 8;
  localparam int unsigned VAL_W      = 9;

  localparam logic [VAL_W-1:0] EOC_CODE = 9'h100;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_FREE   = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BADHEAD = 2'd2,
    ST_LOOP    = 2'd3
  } status_e;

  typedef struct packed {
    mode_e             mode;
    logic [HEAD_W-1:0] head_block;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] block_value;
    status_e          status;
  } out_item_t;

  // classification of one link value
  typedef struct packed {
    logic is_zero;
    logic is_eoc;
    logic is_block;
  } link_class_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fca_ram.sv
// ----------------------------------------------------------------------------
// fca_ram: generic single-write, single-read RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
`default_nettype none

module fca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fca_link_eval.sv
// ----------------------------------------------------------------------------
// fca_link_eval: link classifier
// Shared compare unit: flags a value as free, end-of-chain or a usable block.
// ----------------------------------------------------------------------------
`default_nettype none

module fca_link_eval (
  input  wire logic [fca_pkg::VAL_W-1:0] value_i,
  output fca_pkg::link_class_t           cls_o
);
  import fca_pkg::*;

  always_comb begin
    cls_o.is_zero  = (value_i == '0);
    cls_o.is_eoc   = (value_i == EOC_CODE);
    cls_o.is_block = (value_i != '0) && (value_i < VAL_W'(USABLE));
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fca_seq.sv
// ----------------------------------------------------------------------------
// fca_seq: allocator sequencer
// Walks chains one link per cycle, scans for the lowest free block, and
// keeps the per-entry valid bits that make a cleared entry read as free.
// ----------------------------------------------------------------------------
`default_nettype none

module fca_seq (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire fca_pkg::in_item_t         in_item_i,
  output logic                           res_valid_o,
  input  wire logic                      res_ready_i,
  output fca_pkg::out_item_t             res_o,
  output logic                           ram_we_o,
  output logic [fca_pkg::IDX_W-1:0]      ram_waddr_o,
  output logic [fca_pkg::VAL_W-1:0]      ram_wdata_o,
  output logic                           ram_re_o,
  output logic [fca_pkg::IDX_W-1:0]      ram_raddr_o,
  input  wire logic [fca_pkg::VAL_W-1:0] ram_rdata_i
);
  import fca_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_WALK,
    S_FREE,
    S_SCAN,
    S_WR_LINK,
    S_WR_EOC,
    S_DONE
  } state_e;

  state_e              state_q, state_d;
  mode_e               mode_q, mode_d;
  logic [IDX_W-1:0]    cur_q, cur_d;
  logic [IDX_W-1:0]    scan_q, scan_d;
  logic [IDX_W-1:0]    free_q, free_d;
  logic [STEP_W-1:0]   steps_q, steps_d;
  logic                first_q, first_d;
  out_item_t           res_q, res_d;
  logic [USABLE-1:0]   vld_q;
  logic                rvld_q, rvld_d;
  logic                clr_en;

  logic [VAL_W-1:0]    entry;
  logic [VAL_W-1:0]    eval_in;
  link_class_t         cls;

  // entries never written, or freed, read as zero
  assign entry   = rvld_q ? ram_rdata_i : '0;
  assign eval_in = (state_q == S_IDLE) ? {1'b0, in_item_i.head_block} : entry;

  fca_link_eval u_eval (
    .value_i (eval_in),
    .cls_o   (cls)
  );

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    cur_d       = cur_q;
    scan_d      = scan_q;
    free_d      = free_q;
    steps_d     = steps_q;
    first_d     = first_q;
    res_d       = res_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = cur_q;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = cur_q;
    clr_en      = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mode_d            = in_item_i.mode;
          cur_d             = in_item_i.head_block[IDX_W-1:0];
          steps_d           = '0;
          first_d           = 1'b1;
          scan_d            = IDX_W'(1);
          res_d.block_value = '0;
          res_d.status      = ST_OK;
          ram_raddr_o       = in_item_i.head_block[IDX_W-1:0];
          case (in_item_i.mode)
            MODE_ALLOC: begin
              state_d = S_SCAN;
            end
            MODE_APPEND, MODE_FREE: begin
              if (!cls.is_block) begin
                res_d.status = ST_BADHEAD;
                state_d      = S_DONE;
              end else begin
                ram_re_o = 1'b1;
                state_d  = (in_item_i.mode == MODE_APPEND) ? S_WALK : S_FREE;
              end
            end
            MODE_READ: begin
              if (!(cls.is_block || cls.is_zero)) begin
                res_d.status = ST_BADHEAD;
                state_d      = S_DONE;
              end else begin
                ram_re_o = 1'b1;
                state_d  = S_READ;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_READ: begin
        res_d.block_value = entry;
        state_d           = S_DONE;
      end

      S_WALK: begin
        if (cls.is_zero) begin
          res_d.status = first_q ? ST_BADHEAD : ST_LOOP;
          state_d      = S_DONE;
        end else if (cls.is_eoc) begin
          state_d = S_SCAN;
        end else if (!cls.is_block || steps_q == STEP_W'(USABLE)) begin
          res_d.status = ST_LOOP;
          state_d      = S_DONE;
        end else begin
          steps_d     = steps_q + STEP_W'(1);
          first_d     = 1'b0;
          cur_d       = entry[IDX_W-1:0];
          ram_re_o    = 1'b1;
          ram_raddr_o = entry[IDX_W-1:0];
        end
      end

      S_FREE: begin
        if (first_q && cls.is_zero) begin
          res_d.status = ST_BADHEAD;
          state_d      = S_DONE;
        end else begin
          // link already captured, so the entry can be dropped now
          clr_en = 1'b1;
          if (cls.is_eoc || !cls.is_block) begin
            state_d = S_DONE;
          end else if (steps_q == STEP_W'(USABLE)) begin
            res_d.status = ST_LOOP;
            state_d      = S_DONE;
          end else begin
            steps_d     = steps_q + STEP_W'(1);
            first_d     = 1'b0;
            cur_d       = entry[IDX_W-1:0];
            ram_re_o    = 1'b1;
            ram_raddr_o = entry[IDX_W-1:0];
          end
        end
      end

      S_SCAN: begin
        if (!vld_q[scan_q]) begin
          free_d  = scan_q;
          state_d = (mode_q == MODE_APPEND) ? S_WR_LINK : S_WR_EOC;
        end else if (scan_q == IDX_W'(USABLE - 1)) begin
          res_d.status = ST_FULL;
          state_d      = S_DONE;
        end else begin
          scan_d = scan_q + IDX_W'(1);
        end
      end

      S_WR_LINK: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = cur_q;
        ram_wdata_o = VAL_W'(free_q);
        state_d     = S_WR_EOC;
      end

      S_WR_EOC: begin
        ram_we_o          = 1'b1;
        ram_waddr_o       = free_q;
        ram_wdata_o       = EOC_CODE;
        res_d.block_value = VAL_W'(free_q);
        state_d           = S_DONE;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // a self-link being cleared must read back as free
  assign rvld_d = vld_q[ram_raddr_o] && !(clr_en && (cur_q == ram_raddr_o));

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= MODE_ALLOC;
      cur_q   <= '0;
      scan_q  <= '0;
      free_q  <= '0;
      steps_q <= '0;
      first_q <= 1'b0;
      res_q   <= '0;
      vld_q   <= '0;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      cur_q   <= cur_d;
      scan_q  <= scan_d;
      free_q  <= free_d;
      steps_q <= steps_d;
      first_q <= first_d;
      res_q   <= res_d;
      if (ram_re_o) begin
        rvld_q <= rvld_d;
      end
      if (ram_we_o) begin
        vld_q[ram_waddr_o] <= 1'b1;
      end
      if (clr_en) begin
        vld_q[cur_q] <= 1'b0;
      end
    end
  end

  // block 0 is reserved and is never written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> ram_waddr_o != '0)
    else $error("write to reserved block");

  // a live entry is never written as free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> ram_wdata_o != '0)
    else $error("zero link written");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[0])
    else $error("reserved block marked in use");

  // a successful allocation never hands out block 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == ST_OK &&
     (mode_q == MODE_ALLOC || mode_q == MODE_APPEND)) |-> res_o.block_value != '0)
    else $error("block 0 allocated");

  // write never coincides with a clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we_o && clr_en))
    else $error("write and clear in the same cycle");

endmodule

`default_nettype wire

FILE: hw/rtl/fat_chain_allocator_core.sv
// ----------------------------------------------------------------------------
// fat_chain_allocator_core: link-table block allocator
// Allocate, append, free and read on a table of next-block links.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries one item {mode, head_block};
//   output channel out_valid_o/out_ready_i returns one item
//   {block_value, status} for every input item, in order.
//   One item is worked on at a time; in_ready_o is high only while idle.
//   Work per item: read fetches one link; allocate scans for the lowest free
//   block; append walks the chain, then scans for a free block; free walks
//   the chain and clears each entry that it passes. Each result goes through
//   the sequencer's result register and then the output register.
//   Chain walks read one link per cycle from the link RAM; the free scan
//   tests one valid bit per cycle.
//   Reset clears all per-entry valid bits at once, so the whole table reads
//   as free right after reset; no clearing pass is needed.
//   A result waits in the output register while the receiver stalls; the
//   next item may be accepted and worked on meanwhile, and its result is
//   held in the sequencer until the output register empties.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_chain_allocator_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire fca_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output fca_pkg::out_item_t      out_item_o
);
  import fca_pkg::*;

  logic             res_valid;
  logic             res_ready;
  out_item_t        res;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [VAL_W-1:0] ram_rdata;
  logic             out_valid_q;
  out_item_t        out_q;

  fca_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  fca_ram #(
    .WIDTH (VAL_W),
    .DEPTH (USABLE)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register: takes a new item when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

FILE: tb/sv/fat_chain_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// fat_chain_allocator_core_tb: self-checking bench for the chain allocator
// A clocked driver offers items from a queue that the stimulus process fills.
// Stimulus is directed at first, then random and steered by the table state.
// A link-table model predicts every result. A clocked monitor compares each
// result with the oldest prediction. Both channels idle in random bursts,
// and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module fat_chain_allocator_core_tb;
  import fca_pkg::*;

  localparam int RANDOM_OPS  = 1850;
  localparam int CALM_TAIL   = 150;
  localparam int DRAIN_WAIT  = 600;
  localparam int CYCLE_LIMIT = 5_000_000;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // model state: one link per block
  logic [VAL_W-1:0] link_tbl [NUM_BLOCKS] = '{default: '0};

  in_item_t  op_q [$];
  out_item_t due_q [$];

  int  n_made      = 0;
  int  n_accepted  = 0;
  int  n_checked   = 0;
  int  errors      = 0;
  int  st_seen [4] = '{default: 0};
  int  peak_used   = 0;
  int  cycle_cnt   = 0;
  int  in_gap      = 0;
  int  out_gap     = 0;
  bit  idle_on     = 1'b1;
  bit  hold_off    = 1'b0;

  fat_chain_allocator_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  initial forever #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // link-table model
  // --------------------------------------------------------------------------
  function automatic bit is_block_link(logic [VAL_W-1:0] v);
    return v != '0 && v < USABLE;
  endfunction

  function automatic bit head_in_use(logic [HEAD_W-1:0] h);
    return is_block_link({1'b0, h}) && link_tbl[h] != '0;
  endfunction

  function automatic int lowest_free_block();
    for (int i = 1; i < USABLE; i++) begin
      if (link_tbl[i] == '0) return i;
    end
    return -1;
  endfunction

  function automatic out_item_t apply_table_op(in_item_t it);
    out_item_t        res;
    logic [VAL_W-1:0] cur;
    logic [VAL_W-1:0] nxt;
    int               f;
    int               steps;
    bit               good;
    res.block_value = '0;
    res.status      = ST_OK;
    case (it.mode)
      MODE_ALLOC: begin
        f = lowest_free_block();
        if (f < 0) begin
          res.status = ST_FULL;
        end else begin
          link_tbl[f]     = EOC_CODE;
          res.block_value = f[VAL_W-1:0];
        end
      end
      MODE_APPEND: begin
        if (!head_in_use(it.head_block)) begin
          res.status = ST_BADHEAD;
        end else begin
          cur   = {1'b0, it.head_block};
          steps = 0;
          good  = 1'b1;
          while (link_tbl[cur] != EOC_CODE) begin
            nxt = link_tbl[cur];
            steps++;
            if (!is_block_link(nxt) || link_tbl[nxt] == '0 || steps > USABLE) begin
              good = 1'b0;
              break;
            end
            cur = nxt;
          end
          // allocation happens only after a clean walk
          if (!good) begin
            res.status = ST_LOOP;
          end else begin
            f = lowest_free_block();
            if (f < 0) begin
              res.status = ST_FULL;
            end else begin
              link_tbl[cur]   = f[VAL_W-1:0];
              link_tbl[f]     = EOC_CODE;
              res.block_value = f[VAL_W-1:0];
            end
          end
        end
      end
      MODE_FREE: begin
        if (!head_in_use(it.head_block)) begin
          res.status = ST_BADHEAD;
        end else begin
          cur   = {1'b0, it.head_block};
          steps = 0;
          // next link is read before the entry is cleared
          while (1'b1) begin
            nxt           = link_tbl[cur];
            link_tbl[cur] = '0;
            if (nxt == EOC_CODE || !is_block_link(nxt)) break;
            steps++;
            if (steps > USABLE) begin
              res.status = ST_LOOP;
              break;
            end
            cur = nxt;
          end
        end
      end
      default: begin
        if (it.head_block >= USABLE) res.status = ST_BADHEAD;
        else res.block_value = link_tbl[it.head_block];
      end
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers, steered by the model table
  // --------------------------------------------------------------------------
  function automatic int blocks_in_use();
    int n;
    n = 0;
    for (int i = 1; i < USABLE; i++) begin
      if (link_tbl[i] != '0) n++;
    end
    return n;
  endfunction

  // random block that no other live block links to; 0 when the table is empty
  function automatic logic [HEAD_W-1:0] some_head();
    bit                linked [NUM_BLOCKS];
    logic [HEAD_W-1:0] heads [$];
    linked = '{default: 1'b0};
    for (int i = 1; i < USABLE; i++) begin
      if (is_block_link(link_tbl[i])) linked[link_tbl[i]] = 1'b1;
    end
    for (int i = 1; i < USABLE; i++) begin
      if (link_tbl[i] != '0 && !linked[i]) heads.push_back(HEAD_W'(i));
    end
    if (heads.size() == 0) return '0;
    return heads[$urandom_range(heads.size() - 1)];
  endfunction

  function automatic logic [HEAD_W-1:0] some_used();
    logic [HEAD_W-1:0] live [$];
    for (int i = 1; i < USABLE; i++) begin
      if (link_tbl[i] != '0) live.push_back(HEAD_W'(i));
    end
    if (live.size() == 0) return HEAD_W'($urandom_range(255, 1));
    return live[$urandom_range(live.size() - 1)];
  endfunction

  task automatic queue_op(mode_e m, logic [HEAD_W-1:0] h);
    in_item_t it;
    it.mode       = m;
    it.head_block = h;
    op_q.push_back(it);
    n_made++;
  endtask

  function automatic void flag(string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endfunction

  // --------------------------------------------------------------------------
  // input driver: takes accepted items into the model
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_ops
    bit taken;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
      in_gap    = 0;
    end else begin
      taken = in_valid && in_ready;
      if (taken) begin
        due_q.push_back(apply_table_op(in_item));
        n_accepted++;
      end
      if (!in_valid || taken) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (op_q.size() > 0) begin
          in_valid <= 1'b1;
          in_item  <= op_q.pop_front();
          if (idle_on && $urandom_range(99) < 20) in_gap = $urandom_range(18, 1);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // output ready: random stall bursts, plus the long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_gap    = 0;
    end else if (hold_off) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(99) < 6) begin
      out_gap    = $urandom_range(17, 0);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : long_hold_off
    wait (n_accepted >= 400);
    @(negedge clk_i);
    hold_off = 1'b1;
    repeat (3000) @(negedge clk_i);
    hold_off = 1'b0;
  end

  // --------------------------------------------------------------------------
  // result monitor
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (due_q.size() == 0) begin
        flag($sformatf("unexpected result: value %0d status %0d",
                       out_item.block_value, out_item.status));
      end else begin
        want = due_q.pop_front();
        n_checked++;
        st_seen[int'(want.status)]++;
        if (out_item.block_value !== want.block_value || out_item.status !== want.status) begin
          flag($sformatf("result %0d: expected value %0d status %0d, got value %0d status %0d",
                         n_checked, want.block_value, want.status,
                         out_item.block_value, out_item.status));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycle_cnt, due_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int                r;
    int                used;
    int                fill_goal;
    bit                calm;
    bit                grow;
    mode_e             m;
    logic [HEAD_W-1:0] h;
    logic [HEAD_W-1:0] last_head;
    fill_goal = 40;
    calm      = 1'b0;
    last_head = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reads at the edges, bad heads, a broken chain and its repair
    queue_op(MODE_READ,   8'd0);
    queue_op(MODE_READ,   8'd255);
    queue_op(MODE_ALLOC,  8'd0);
    queue_op(MODE_ALLOC,  8'd0);
    queue_op(MODE_APPEND, 8'd1);
    queue_op(MODE_APPEND, 8'd1);
    queue_op(MODE_READ,   8'd1);
    queue_op(MODE_READ,   8'd3);
    queue_op(MODE_READ,   8'd4);
    queue_op(MODE_APPEND, 8'd0);
    queue_op(MODE_APPEND, 8'd255);
    queue_op(MODE_FREE,   8'd0);
    queue_op(MODE_FREE,   8'd200);
    queue_op(MODE_FREE,   8'd3);    // frees the tail, block 1 now dangles
    queue_op(MODE_APPEND, 8'd1);    // walk hits a free entry
    queue_op(MODE_ALLOC,  8'd0);    // reuses the dangling target
    queue_op(MODE_READ,   8'd1);
    queue_op(MODE_FREE,   8'd1);
    queue_op(MODE_FREE,   8'd2);
    queue_op(MODE_READ,   8'd2);
    queue_op(MODE_ALLOC,  8'hFF);   // head ignored
    while (n_accepted != n_made) @(negedge clk_i);

    // random: fill to a moving target, then drain, one item at a time
    for (int k = 0; k < RANDOM_OPS; k++) begin
      if (k % 120 == 0) begin
        case ($urandom_range(4))
          0:       fill_goal = 8;
          1:       fill_goal = 40;
          2:       fill_goal = 100;
          3:       fill_goal = 180;
          default: fill_goal = 255;
        endcase
        calm = ($urandom_range(3) == 0);
      end
      idle_on = !calm && (k < RANDOM_OPS - CALM_TAIL);
      used    = blocks_in_use();
      if (used > peak_used) peak_used = used;
      grow = used < fill_goal;
      r    = $urandom_range(99);
      if (r < 8) begin
        m = mode_e'($urandom_range(3));
        h = HEAD_W'($urandom_range(255));
      end else if (r < 22) begin
        m = MODE_READ;
        h = $urandom_range(1) ? some_used() : HEAD_W'($urandom_range(255));
      end else if (grow ? r < 40 : r < 30) begin
        m = MODE_ALLOC;
        h = HEAD_W'($urandom_range(255));
      end else if (grow ? r < 90 : r < 45) begin
        // keep growing one chain now and then so that long walks occur
        m = MODE_APPEND;
        if (last_head != '0 && link_tbl[last_head] != '0 && $urandom_range(1)) h = last_head;
        else h = some_head();
        last_head = h;
      end else begin
        m = MODE_FREE;
        h = ($urandom_range(9) < 7) ? some_head() : some_used();
      end
      queue_op(m, h);
      while (n_accepted != n_made) @(negedge clk_i);
    end

    while (due_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    $display("Checked %0d results: %0d ok, %0d table full, %0d bad head, %0d broken chain",
             n_checked, st_seen[0], st_seen[1], st_seen[2], st_seen[3]);
    $display("Peak table use %0d blocks, %0d mismatches in %0d cycles",
             peak_used, errors, cycle_cnt);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/fca_pkg.sv
hw/rtl/fca_ram.sv
hw/rtl/fca_link_eval.sv
hw/rtl/fca_seq.sv
hw/rtl/fat_chain_allocator_core.sv
tb/sv/fat_chain_allocator_core_tb.sv
